[src/irn_pkg.sv]
// Shared constants, types and digit-pattern functions for the Roman numeral converter.
package irn_pkg;

	localparam int ValueW   = 12;
	localparam int SymW     = 8;
	localparam int DigitW   = 4;
	localparam int NumRanks = 4;
	localparam int RankW    = 2;
	localparam int PosW     = 2;
	localparam int LenW     = 3;
	localparam int CountW   = 4;

	localparam logic [ValueW-1:0] MaxValue = ValueW'(3999);

	localparam logic [SymW-1:0] SymM    = 8'h4D;
	localparam logic [SymW-1:0] SymD    = 8'h44;
	localparam logic [SymW-1:0] SymC    = 8'h43;
	localparam logic [SymW-1:0] SymL    = 8'h4C;
	localparam logic [SymW-1:0] SymX    = 8'h58;
	localparam logic [SymW-1:0] SymV    = 8'h56;
	localparam logic [SymW-1:0] SymI    = 8'h49;
	localparam logic [SymW-1:0] SymNone = 8'h00;

	// rank 0 is thousands, rank 3 is units
	localparam logic [RankW-1:0] RankThousands = 2'd0;
	localparam logic [RankW-1:0] RankHundreds  = 2'd1;
	localparam logic [RankW-1:0] RankTens      = 2'd2;
	localparam logic [RankW-1:0] RankUnits     = 2'd3;

	typedef logic [NumRanks-1:0][DigitW-1:0] digits_t;

	typedef enum logic [1:0] {
		SLOT_ONE,
		SLOT_FIVE,
		SLOT_TEN
	} slot_t;

	typedef struct packed {
		logic            busy;
		digits_t         digits;
	} bcd_stat_t;

	typedef struct packed {
		logic            strobe;
		logic [SymW-1:0] symbol;
		logic            last;
	} emit_t;

	// number of characters a decimal digit expands to
	function automatic logic [LenW-1:0] digit_len(input logic [DigitW-1:0] d);
		logic [LenW-1:0] n;
		case (d)
			4'd0:    n = 3'd0;
			4'd1:    n = 3'd1;
			4'd2:    n = 3'd2;
			4'd3:    n = 3'd3;
			4'd4:    n = 3'd2;
			4'd5:    n = 3'd1;
			4'd6:    n = 3'd2;
			4'd7:    n = 3'd3;
			4'd8:    n = 3'd4;
			4'd9:    n = 3'd2;
			default: n = 3'd0;
		endcase
		return n;
	endfunction

	// which symbol of the rank sits at character position k of digit d
	function automatic slot_t slot_sel(input logic [DigitW-1:0] d,
			input logic [PosW-1:0] k);
		slot_t s;
		s = SLOT_ONE;
		if (d == 4'd9) begin
			s = (k == 2'd0) ? SLOT_ONE : SLOT_TEN;
		end else if (d == 4'd4) begin
			s = (k == 2'd0) ? SLOT_ONE : SLOT_FIVE;
		end else if (d >= 4'd5 && k == 2'd0) begin
			s = SLOT_FIVE;
		end
		return s;
	endfunction

	function automatic logic [SymW-1:0] rank_sym(input logic [RankW-1:0] r, input slot_t s);
		logic [SymW-1:0] c;
		c = SymM;
		case (r)
			RankThousands: c = SymM;
			RankHundreds: begin
				case (s)
					SLOT_ONE:  c = SymC;
					SLOT_FIVE: c = SymD;
					default:   c = SymM;
				endcase
			end
			RankTens: begin
				case (s)
					SLOT_ONE:  c = SymX;
					SLOT_FIVE: c = SymL;
					default:   c = SymC;
				endcase
			end
			default: begin
				case (s)
					SLOT_ONE:  c = SymI;
					SLOT_FIVE: c = SymV;
					default:   c = SymX;
				endcase
			end
		endcase
		return c;
	endfunction

endpackage

[src/irn_bcd.sv]
// Bit-serial binary to BCD converter (shift and add-3), one input bit per cycle.
module irn_bcd (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic [irn_pkg::ValueW-1:0]  value,
	output irn_pkg::bcd_stat_t          stat
);

	localparam int BcdW = irn_pkg::NumRanks * irn_pkg::DigitW;

	logic [irn_pkg::ValueW-1:0] bin_q;
	logic [BcdW-1:0]            bcd_q;
	logic [irn_pkg::CountW-1:0] cnt_q;
	logic [BcdW-1:0]            adj;

	// add 3 to every nibble of 5 or more before the shift
	always_comb begin
		for (int i = 0; i < irn_pkg::NumRanks; i++) begin
			if (bcd_q[i*irn_pkg::DigitW +: irn_pkg::DigitW] >= 4'd5) begin
				adj[i*irn_pkg::DigitW +: irn_pkg::DigitW] =
					bcd_q[i*irn_pkg::DigitW +: irn_pkg::DigitW] + 4'd3;
			end else begin
				adj[i*irn_pkg::DigitW +: irn_pkg::DigitW] =
					bcd_q[i*irn_pkg::DigitW +: irn_pkg::DigitW];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (start) begin
			cnt_q <= irn_pkg::CountW'(irn_pkg::ValueW);
		end else if (cnt_q != '0) begin
			cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			bin_q <= value;
			bcd_q <= '0;
		end else if (cnt_q != '0) begin
			bcd_q <= {adj[BcdW-2:0], bin_q[irn_pkg::ValueW-1]};
			bin_q <= {bin_q[irn_pkg::ValueW-2:0], 1'b0};
		end
	end

	// digits[0] is thousands
	assign stat.busy      = (cnt_q != '0);
	assign stat.digits[0] = bcd_q[15:12];
	assign stat.digits[1] = bcd_q[11:8];
	assign stat.digits[2] = bcd_q[7:4];
	assign stat.digits[3] = bcd_q[3:0];

endmodule

[src/irn_emit.sv]
// Character sequencer: walks ranks and pattern positions, one numeral character per run cycle.
module irn_emit (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 load,
	input  logic                 run,
	input  irn_pkg::digits_t     digits,
	output irn_pkg::emit_t       emit
);

	logic [irn_pkg::RankW-1:0]  rank_q;
	logic [irn_pkg::PosW-1:0]   pos_q;
	logic [irn_pkg::DigitW-1:0] cur_d;
	logic [irn_pkg::LenW-1:0]   len;
	logic                       has_char;
	logic                       digit_end;
	logic [irn_pkg::NumRanks-1:0] tail_zero;

	// tail_zero[r]: every less significant rank (index above r) has digit zero
	always_comb begin
		tail_zero[irn_pkg::NumRanks-1] = 1'b1;
		for (int r = irn_pkg::NumRanks - 2; r >= 0; r--) begin
			tail_zero[r] = tail_zero[r+1] && (digits[r+1] == '0);
		end
	end

	always_comb begin
		cur_d     = digits[rank_q];
		len       = irn_pkg::digit_len(cur_d);
		has_char  = ({1'b0, pos_q} < len);
		digit_end = ({1'b0, pos_q} + 1'b1 == len);
		emit.strobe = run && has_char;
		emit.symbol = irn_pkg::rank_sym(rank_q, irn_pkg::slot_sel(cur_d, pos_q));
		emit.last   = digit_end && tail_zero[rank_q];
	end

	// an empty digit emits no character; the rank advances past it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rank_q <= '0;
			pos_q  <= '0;
		end else if (load) begin
			rank_q <= '0;
			pos_q  <= '0;
		end else if (run) begin
			if (has_char && !digit_end) begin
				pos_q <= pos_q + 1'b1;
			end else begin
				rank_q <= rank_q + 1'b1;
				pos_q  <= '0;
			end
		end
	end

endmodule

[src/integer_to_roman_numeral.sv]
// Top level: integer to Roman numeral converter, ASCII characters out one per strobe.
//
//  channel   ports                                  handshake
//  item in   value[11:0]                            start && !busy
//  result    symbol[7:0], last, out_of_range        strobe (one cycle, no stall)
//
// A valid item is accepted, shifted bit by bit through the BCD converter, handed over as
// digits, then emitted character by character; zero digits give no character.
// An item of 0 or above 3999 gives its single error result the cycle after
// acceptance and leaves busy low. Reset clears control and output registers, not BCD data.
// The receiver takes every result as it appears; busy is the only back pressure.
module integer_to_roman_numeral (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	output logic                       busy,
	input  logic [irn_pkg::ValueW-1:0] value,
	output logic                       strobe,
	output logic [irn_pkg::SymW-1:0]   symbol,
	output logic                       last,
	output logic                       out_of_range
);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_CONV,
		ST_EMIT
	} state_t;

	state_t                    state_q;
	logic                      strobe_q;
	logic [irn_pkg::SymW-1:0]  symbol_q;
	logic                      last_q;
	logic                      oor_q;

	logic                      accept;
	logic                      bad;
	logic                      bcd_start;
	logic                      run;
	irn_pkg::bcd_stat_t        bcd_stat;
	irn_pkg::emit_t            emit;

	assign accept    = start && (state_q == ST_IDLE);
	assign bad       = (value == '0) || (value > irn_pkg::MaxValue);
	assign bcd_start = accept && !bad;
	assign run       = (state_q == ST_EMIT);

	irn_bcd u_bcd (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (bcd_start),
		.value  (value),
		.stat   (bcd_stat)
	);

	irn_emit u_emit (
		.clk    (clk),
		.arst_n (arst_n),
		.load   (bcd_start),
		.run    (run),
		.digits (bcd_stat.digits),
		.emit   (emit)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			strobe_q <= 1'b0;
			symbol_q <= '0;
			last_q   <= 1'b0;
			oor_q    <= 1'b0;
		end else begin
			strobe_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						if (bad) begin
							strobe_q <= 1'b1;
							symbol_q <= irn_pkg::SymNone;
							last_q   <= 1'b1;
							oor_q    <= 1'b1;
						end else begin
							state_q <= ST_CONV;
						end
					end
				end
				ST_CONV: begin
					if (!bcd_stat.busy) begin
						state_q <= ST_EMIT;
					end
				end
				ST_EMIT: begin
					if (emit.strobe) begin
						strobe_q <= 1'b1;
						symbol_q <= emit.symbol;
						last_q   <= emit.last;
						oor_q    <= 1'b0;
						if (emit.last) begin
							state_q <= ST_IDLE;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign busy         = (state_q != ST_IDLE);
	assign strobe       = strobe_q;
	assign symbol       = symbol_q;
	assign last         = last_q;
	assign out_of_range = oor_q;

endmodule
